FILE: rtl/at_rlt_pkg.sv
// ============================================================================
// at_rlt_pkg : shared types and constants for the AT response line tracker
// Word layouts, action and status codes, line classes and the text matchers.
// ============================================================================
`default_nettype none

package at_rlt_pkg;

    localparam int CFG_W = 24;

    // configuration register indexes
    localparam logic REG_DEFAULT_TIMEOUT = 1'b0;
    localparam logic REG_FORWARD_UNSOL   = 1'b1;

    // action codes
    localparam logic [2:0] ACT_RX_BYTE   = 3'd0;
    localparam logic [2:0] ACT_START     = 3'd1;
    localparam logic [2:0] ACT_TICK      = 3'd2;
    localparam logic [2:0] ACT_CLEAR     = 3'd3;
    localparam logic [2:0] ACT_READ_RESP = 3'd4;
    localparam logic [2:0] ACT_READ_LAST = 3'd5;

    // command status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PENDING = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_TIMEOUT = 2'd3;

    // line events
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_FINAL_OK  = 3'd1;
    localparam logic [2:0] EV_FINAL_ERR = 3'd2;
    localparam logic [2:0] EV_INTER     = 3'd3;
    localparam logic [2:0] EV_UNSOL     = 3'd4;
    localparam logic [2:0] EV_INTER_FWD = 3'd5;

    // characters
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_PROMPT = ">";
    localparam logic [7:0] CHR_COLON  = ":";
    localparam logic [7:0] CHR_PLUS   = "+";

    // match flag bit positions
    localparam int MF_OK_BAD  = 0;
    localparam int MF_ERR_BAD = 1;
    localparam int MF_CME_BAD = 2;
    localparam int MF_CMS_BAD = 3;
    localparam int MF_COLON   = 4;
    localparam int MF_PLUS    = 5;

    typedef logic [5:0] match_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  rx_byte;
        logic [23:0] cmd_timeout;
        logic [5:0]  read_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        busy_flag;
        logic [2:0]  line_event;
        logic        accepted;
        logic [5:0]  data_length;
        logic [7:0]  data_byte;
        logic [15:0] error_total;
        logic [15:0] timeout_total;
    } out_word_t;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_CHAR,
        CLS_CR,
        CLS_LF,
        CLS_START,
        CLS_TICK,
        CLS_CLEAR,
        CLS_RD_RESP,
        CLS_RD_LAST
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [7:0]  rx_byte;
        logic [23:0] cmd_timeout;
        logic [5:0]  read_index;
    } q_entry_t;

    function automatic logic [7:0] ok_char(input logic pos);
        return pos ? 8'("K") : 8'("O");
    endfunction

    function automatic logic [7:0] err_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "E";
            3'd1:    c = "R";
            3'd2:    c = "R";
            3'd3:    c = "O";
            3'd4:    c = "R";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "+CME ERROR" / "+CMS ERROR"
    function automatic logic [7:0] cm_char(input logic [3:0] pos, input logic sms);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "+";
            4'd1:    c = "C";
            4'd2:    c = "M";
            4'd3:    c = sms ? 8'("S") : 8'("E");
            4'd4:    c = " ";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "R";
            4'd8:    c = "O";
            4'd9:    c = "R";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // flags raised by character c at line position pos
    function automatic match_t char_match(input logic [7:0] pos, input logic [7:0] c);
        match_t m;
        m = '0;
        if (pos >= 8'd2 || ok_char(pos[0]) != c)
            m[MF_OK_BAD] = 1'b1;
        if (pos >= 8'd5 || err_char(pos[2:0]) != c)
            m[MF_ERR_BAD] = 1'b1;
        if (pos < 8'd10 && cm_char(pos[3:0], 1'b0) != c)
            m[MF_CME_BAD] = 1'b1;
        if (pos < 8'd10 && cm_char(pos[3:0], 1'b1) != c)
            m[MF_CMS_BAD] = 1'b1;
        if (c == CHR_COLON)
            m[MF_COLON] = 1'b1;
        if (pos == 8'd0 && c == CHR_PLUS)
            m[MF_PLUS] = 1'b1;
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/at_response_line_tracker_top.sv
// ============================================================================
// at_response_line_tracker_top : AT command response line tracker
// Follows modem reply text a character at a time, classifies completed lines
// and tracks command status, timeout and line stores.
// ============================================================================
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------
//  in      | in_valid / in_stall     | in_word  (action, byte, timeout, index)
//  out     | out_valid / out_stall   | out_word (status, event, data, totals)
//  cfg     | cfg_write               | cfg_index, cfg_data
//
//  One word a cycle sustained while out_stall stays low; a result word passes
//  through the queue entry, then the execute stage with the store RAM read,
//  before it is valid on out.
//  Reset takes effect at once; the line stores are not cleared.
//  out_stall holds the result word and backs up into the two-entry queue;
//  in_stall rises only when that queue is full.
// ============================================================================
`default_nettype none

module at_response_line_tracker_top
    import at_rlt_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_word_t         in_word,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_word_t             out_word,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic     head_valid;
    q_entry_t head;
    logic     pop;

    at_rlt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    at_rlt_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

`default_nettype wire

FILE: rtl/at_rlt_ram.sv
// ============================================================================
// at_rlt_ram : generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module at_rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 192
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/at_rlt_front.sv
// ============================================================================
// at_rlt_front : input side of the AT response line tracker
// Accepts words, sorts each into a line class and queues it (two entries).
// ============================================================================
`default_nettype none

module at_rlt_front
    import at_rlt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_word_t in_word,
    output logic          head_valid,
    output q_entry_t      head,
    input  wire logic     pop
);

    q_entry_t   fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    q_entry_t   entry;
    logic       push;

    always_comb
    begin
        entry.rx_byte     = in_word.rx_byte;
        entry.cmd_timeout = in_word.cmd_timeout;
        entry.read_index  = in_word.read_index;
        case (in_word.action)
            ACT_RX_BYTE:
            begin
                if (in_word.rx_byte == CHR_CR)
                    entry.cls = CLS_CR;
                else if (in_word.rx_byte == CHR_LF)
                    entry.cls = CLS_LF;
                else
                    entry.cls = CLS_CHAR;
            end
            ACT_START:     entry.cls = CLS_START;
            ACT_TICK:      entry.cls = CLS_TICK;
            ACT_CLEAR:     entry.cls = CLS_CLEAR;
            ACT_READ_RESP: entry.cls = CLS_RD_RESP;
            ACT_READ_LAST: entry.cls = CLS_RD_LAST;
            default:       entry.cls = CLS_NONE;
        endcase
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign head       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/at_rlt_back.sv
// ============================================================================
// at_rlt_back : execution side of the AT response line tracker
// Runs one queued word a cycle unless out_stall holds the result: line assembly,
// classification, command timer, store reads, and holds the result word until taken.
// ============================================================================
`default_nettype none

module at_rlt_back
    import at_rlt_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             head_valid,
    input  wire q_entry_t         head,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_word_t             out_word
);

    localparam int LW    = $clog2(LINE_MAX);
    localparam int DEPTH = 3 * LINE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (LW > 6) ? LW : 6;
    localparam logic [LW-1:0] LEN_FULL = LW'(LINE_MAX - 1);
    localparam logic [AW-1:0] BASE1    = AW'(LINE_MAX);
    localparam logic [AW-1:0] BASE2    = AW'(2 * LINE_MAX);

    function automatic logic [AW-1:0] store_base(input logic [1:0] role);
        logic [AW-1:0] b;
        case (role)
            2'd1:    b = BASE1;
            2'd2:    b = BASE2;
            default: b = '0;
        endcase
        return b;
    endfunction

    logic [23:0]   dflt_tmo_reg, dflt_tmo_next;
    logic          fwd_reg, fwd_next;
    logic          busy_reg, busy_next;
    logic [1:0]    result_reg, result_next;
    logic [23:0]   elapsed_reg, elapsed_next;
    logic [23:0]   limit_reg, limit_next;
    logic [1:0]    role_asm_reg, role_asm_next;
    logic [1:0]    role_last_reg, role_last_next;
    logic [1:0]    role_resp_reg, role_resp_next;
    logic [LW-1:0] asm_len_reg, asm_len_next;
    logic [LW-1:0] last_len_reg, last_len_next;
    logic [LW-1:0] resp_len_reg, resp_len_next;
    match_t        flags_reg, flags_next;
    logic [15:0]   err_cnt_reg, err_cnt_next;
    logic [15:0]   tmo_cnt_reg, tmo_cnt_next;
    logic          res_valid_reg, res_valid_next;
    out_word_t     res_reg, res_next;
    logic          hit_reg, hit_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;

    logic          room;
    match_t        flags_upd;
    logic [LW-1:0] len_inc;
    logic [23:0]   elapsed_inc;
    logic          fin_do;
    logic [LW-1:0] fin_len;
    match_t        fin_flags;
    logic          ok_hit, err_hit, as_resp;
    logic [2:0]    ev;
    logic          acc;
    logic [5:0]    dlen;

    assign pop = head_valid && (!res_valid_reg || !out_stall);

    always_comb
    begin
        dflt_tmo_next  = dflt_tmo_reg;
        fwd_next       = fwd_reg;
        busy_next      = busy_reg;
        result_next    = result_reg;
        elapsed_next   = elapsed_reg;
        limit_next     = limit_reg;
        role_asm_next  = role_asm_reg;
        role_last_next = role_last_reg;
        role_resp_next = role_resp_reg;
        asm_len_next   = asm_len_reg;
        last_len_next  = last_len_reg;
        resp_len_next  = resp_len_reg;
        flags_next     = flags_reg;
        err_cnt_next   = err_cnt_reg;
        tmo_cnt_next   = tmo_cnt_reg;

        ev       = EV_NONE;
        acc      = 1'b0;
        dlen     = '0;
        hit_next = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = store_base(role_asm_reg) + AW'(asm_len_reg);
        rd_en    = 1'b0;
        rd_addr  = '0;
        as_resp  = 1'b0;

        room        = (asm_len_reg < LEN_FULL);
        flags_upd   = flags_reg | char_match(8'(asm_len_reg), head.rx_byte);
        len_inc     = asm_len_reg + 1'b1;
        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 24'd1 : elapsed_reg;

        fin_do    = 1'b0;
        fin_len   = asm_len_reg;
        fin_flags = flags_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_DEFAULT_TIMEOUT: dflt_tmo_next = cfg_data;
                REG_FORWARD_UNSOL:   fwd_next      = cfg_data[0];
                default:             ;
            endcase
        end

        if (pop)
        begin
            case (head.cls)
                CLS_CHAR:
                begin
                    if (room)
                    begin
                        wr_en        = 1'b1;
                        flags_next   = flags_upd;
                        asm_len_next = len_inc;
                    end
                    // a lone prompt closes the line at once
                    if (asm_len_reg == '0 && head.rx_byte == CHR_PROMPT)
                    begin
                        fin_do    = 1'b1;
                        fin_len   = len_inc;
                        fin_flags = flags_upd;
                    end
                end
                CLS_LF:
                begin
                    fin_do = 1'b1;
                end
                CLS_START:
                begin
                    if (!busy_reg)
                    begin
                        busy_next     = 1'b1;
                        result_next   = ST_PENDING;
                        resp_len_next = '0;
                        limit_next    = (head.cmd_timeout != '0) ? head.cmd_timeout
                                                                 : dflt_tmo_reg;
                        elapsed_next  = '0;
                        acc           = 1'b1;
                    end
                end
                CLS_TICK:
                begin
                    if (busy_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= limit_reg)
                        begin
                            busy_next    = 1'b0;
                            tmo_cnt_next = tmo_cnt_reg + 16'd1;
                            result_next  = ST_TIMEOUT;
                        end
                    end
                end
                CLS_CLEAR:
                begin
                    busy_next     = 1'b0;
                    asm_len_next  = '0;
                    flags_next    = '0;
                    resp_len_next = '0;
                    result_next   = ST_OK;
                end
                CLS_RD_RESP:
                begin
                    dlen     = 6'(resp_len_reg);
                    hit_next = (CW'(head.read_index) < CW'(resp_len_reg));
                    rd_en    = hit_next;
                    rd_addr  = store_base(role_resp_reg) + AW'(head.read_index);
                end
                CLS_RD_LAST:
                begin
                    dlen     = 6'(last_len_reg);
                    hit_next = (CW'(head.read_index) < CW'(last_len_reg));
                    rd_en    = hit_next;
                    rd_addr  = store_base(role_last_reg) + AW'(head.read_index);
                end
                default: ;
            endcase
        end

        ok_hit  = !fin_flags[MF_OK_BAD] && fin_len == LW'(2);
        err_hit = (!fin_flags[MF_ERR_BAD] && fin_len == LW'(5))
               || (!fin_flags[MF_CME_BAD] && fin_len >= LW'(10))
               || (!fin_flags[MF_CMS_BAD] && fin_len >= LW'(10));

        if (fin_do)
        begin
            asm_len_next = '0;
            flags_next   = '0;
            dlen         = 6'(fin_len);
            if (fin_len != '0)
            begin
                if (busy_reg)
                begin
                    if (ok_hit)
                    begin
                        busy_next   = 1'b0;
                        result_next = ST_OK;
                        ev          = EV_FINAL_OK;
                    end
                    else if (err_hit)
                    begin
                        busy_next    = 1'b0;
                        err_cnt_next = err_cnt_reg + 16'd1;
                        result_next  = ST_ERROR;
                        as_resp      = 1'b1;
                        ev           = EV_FINAL_ERR;
                    end
                    else
                    begin
                        as_resp = 1'b1;
                        ev = (fin_flags[MF_PLUS] && fin_flags[MF_COLON] && fwd_reg)
                           ? EV_INTER_FWD : EV_INTER;
                    end
                end
                else
                begin
                    ev = fwd_reg ? EV_UNSOL : EV_NONE;
                end

                // stores swap roles, no copy
                if (as_resp)
                begin
                    role_asm_next  = role_resp_reg;
                    role_resp_next = role_asm_reg;
                    resp_len_next  = fin_len;
                end
                else
                begin
                    role_asm_next = role_asm_reg ^ role_resp_reg ^ 2'd3;
                end
                role_last_next = role_asm_reg;
                last_len_next  = fin_len;
            end
        end

        res_next.status        = result_next;
        res_next.busy_flag     = busy_next;
        res_next.line_event    = ev;
        res_next.accepted      = acc;
        res_next.data_length   = dlen;
        res_next.data_byte     = 8'h00;
        res_next.error_total   = err_cnt_next;
        res_next.timeout_total = tmo_cnt_next;

        if (pop)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dflt_tmo_reg  <= 24'd1000;
            fwd_reg       <= 1'b1;
            busy_reg      <= 1'b0;
            result_reg    <= ST_OK;
            elapsed_reg   <= '0;
            limit_reg     <= '0;
            role_asm_reg  <= 2'd0;
            role_last_reg <= 2'd1;
            role_resp_reg <= 2'd2;
            asm_len_reg   <= '0;
            last_len_reg  <= '0;
            resp_len_reg  <= '0;
            flags_reg     <= '0;
            err_cnt_reg   <= '0;
            tmo_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            dflt_tmo_reg  <= dflt_tmo_next;
            fwd_reg       <= fwd_next;
            busy_reg      <= busy_next;
            result_reg    <= result_next;
            elapsed_reg   <= elapsed_next;
            limit_reg     <= limit_next;
            role_asm_reg  <= role_asm_next;
            role_last_reg <= role_last_next;
            role_resp_reg <= role_resp_next;
            asm_len_reg   <= asm_len_next;
            last_len_reg  <= last_len_next;
            resp_len_reg  <= resp_len_next;
            flags_reg     <= flags_next;
            err_cnt_reg   <= err_cnt_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
            hit_reg <= hit_next;
        end
    end

    at_rlt_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (head.rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // read data lands with the result word; bytes past the length read as zero
    always_comb
    begin
        out_word           = res_reg;
        out_word.data_byte = hit_reg ? rd_data : res_reg.data_byte;
    end

    assign out_valid = res_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/at_rlt_checker.sv
// ============================================================================
// at_rlt_checker : port-level checks for the AT response line tracker
// Watches the output channel for status consistency; bound to the top level.
// ============================================================================
`default_nettype none

module at_rlt_checker
    import at_rlt_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    // held result word must not move
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.busy_flag |-> out_word.status == ST_PENDING)
        else $error("busy without pending status");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.accepted |-> out_word.busy_flag)
        else $error("command accepted but not busy");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.line_event == EV_FINAL_OK
                      || out_word.line_event == EV_FINAL_ERR)
        |-> !out_word.busy_flag
            && (out_word.status == ST_OK || out_word.status == ST_ERROR))
        else $error("final response left command open");

endmodule

bind at_response_line_tracker_top at_rlt_checker u_at_rlt_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top : testbench for at_response_line_tracker_top
// A short table of directed words, then random modem reply traffic: command
// exchanges, unsolicited and prompt lines, reads, ticks, clears and noise.
// Both sides idle at random but in the last phase. Every reply word is predicted
// here and checked field by field in order.
// ============================================================================

module tb_top;
    import at_rlt_pkg::*;

    localparam int          LINE_MAX    = 64;
    localparam logic [2:0]  ACT_SPARE_6 = 3'd6;
    localparam logic [2:0]  ACT_SPARE_7 = 3'd7;
    localparam logic [23:0] TMO_MAX     = 24'hFFFFFF;
    localparam int          MAX_REPORTS = 10;
    localparam int          PHASE_WORDS = 270;

    typedef struct {
        in_word_t  w;
        bit        typed;
        out_word_t want;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_word_t         in_word;
    logic             out_valid;
    logic             out_stall;
    out_word_t        out_word;
    logic             cfg_write;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // typed expectation travelling with the word on the input channel
    bit               typed_row;
    out_word_t        typed_word;

    int tx_idle_pct;
    int rx_idle_pct;

    // tracker model state
    logic [23:0] p_def_tmo;
    logic        p_fwd;
    logic        p_busy;
    logic [1:0]  p_status;
    logic [23:0] p_elapsed;
    logic [23:0] p_limit;
    logic [7:0]  p_store [0:3*LINE_MAX-1];
    int          p_asm, p_last, p_resp;
    int          p_asm_len, p_last_len, p_resp_len;
    logic [15:0] p_err_cnt, p_tmo_cnt;

    out_word_t reply_q[$];
    row_t      directed_rows[$];

    int words_sent;
    int replies_checked;
    int mismatches;
    int lines_closed;
    int finals_ok;
    int finals_err;
    int timeouts_seen;

    at_response_line_tracker_top #(
        .LINE_MAX (LINE_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #(5_000_000);
        $display("watchdog expired with %0d replies outstanding", reply_q.size());
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    task automatic model_reset();
        p_def_tmo  = 24'd1000;
        p_fwd      = 1'b1;
        p_busy     = 1'b0;
        p_status   = ST_OK;
        p_elapsed  = '0;
        p_limit    = '0;
        for (int i = 0; i < 3 * LINE_MAX; i++)
            p_store[i] = '0;
        p_asm      = 0;
        p_last     = 1;
        p_resp     = 2;
        p_asm_len  = 0;
        p_last_len = 0;
        p_resp_len = 0;
        p_err_cnt  = '0;
        p_tmo_cnt  = '0;
    endtask

    // whole-line or prefix match of the line being assembled
    function automatic bit asm_text(input string pat, input int len, input bit as_prefix);
        int base;
        bit same;
        base = p_asm * LINE_MAX;
        same = as_prefix ? (len >= pat.len()) : (len == pat.len());
        for (int i = 0; i < pat.len() && same; i++)
            if (p_store[base + i] != pat[i])
                same = 1'b0;
        return same;
    endfunction

    function automatic bit asm_has_colon(input int len);
        bit seen;
        seen = 1'b0;
        for (int i = 0; i < len; i++)
            if (p_store[p_asm * LINE_MAX + i] == CHR_COLON)
                seen = 1'b1;
        return seen;
    endfunction

    function automatic logic [7:0] store_byte(input int role, input int len,
                                              input logic [5:0] idx);
        if (int'(idx) >= len)
            return 8'h00;
        return p_store[role * LINE_MAX + int'(idx)];
    endfunction

    // ends the assembled line: classify, then hand the store its new role
    function automatic logic [2:0] close_line(output logic [5:0] len_out);
        int         len;
        int         done;
        logic [2:0] ev;
        bit         keep;
        len       = p_asm_len;
        done      = p_asm;
        ev        = EV_NONE;
        keep      = 1'b0;
        p_asm_len = 0;
        len_out   = 6'(len);
        if (len == 0)
            return EV_NONE;
        lines_closed++;
        if (p_busy) begin
            if (asm_text("OK", len, 1'b0)) begin
                p_busy   = 1'b0;
                p_status = ST_OK;
                ev       = EV_FINAL_OK;
                finals_ok++;
            end else if (asm_text("ERROR", len, 1'b0) || asm_text("+CME ERROR", len, 1'b1) ||
                         asm_text("+CMS ERROR", len, 1'b1)) begin
                p_busy    = 1'b0;
                p_status  = ST_ERROR;
                p_err_cnt = p_err_cnt + 16'd1;
                ev        = EV_FINAL_ERR;
                keep      = 1'b1;
                finals_err++;
            end else begin
                keep = 1'b1;
                ev   = (p_store[p_asm * LINE_MAX] == CHR_PLUS && asm_has_colon(len) && p_fwd)
                       ? EV_INTER_FWD : EV_INTER;
            end
        end else begin
            ev = p_fwd ? EV_UNSOL : EV_NONE;
        end
        if (keep) begin
            p_asm      = p_resp;
            p_resp     = done;
            p_resp_len = len;
        end else begin
            p_asm = 3 - done - p_resp;
        end
        p_last     = done;
        p_last_len = len;
        return ev;
    endfunction

    function automatic out_word_t track_step(input in_word_t w);
        out_word_t  r;
        logic [2:0] ev;
        logic       acc;
        logic [5:0] dlen;
        logic [7:0] dbyte;
        ev    = EV_NONE;
        acc   = 1'b0;
        dlen  = '0;
        dbyte = '0;
        case (w.action)
            ACT_RX_BYTE:
            begin
                if (w.rx_byte == CHR_LF) begin
                    ev = close_line(dlen);
                end else if (w.rx_byte != CHR_CR) begin
                    if (p_asm_len < LINE_MAX - 1) begin
                        p_store[p_asm * LINE_MAX + p_asm_len] = w.rx_byte;
                        p_asm_len++;
                    end
                    // a lone prompt is a line of its own
                    if (p_asm_len == 1 && w.rx_byte == CHR_PROMPT)
                        ev = close_line(dlen);
                end
            end
            ACT_START:
            begin
                if (!p_busy) begin
                    p_busy     = 1'b1;
                    p_status   = ST_PENDING;
                    p_resp_len = 0;
                    p_limit    = (w.cmd_timeout != '0) ? w.cmd_timeout : p_def_tmo;
                    p_elapsed  = '0;
                    acc        = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (p_busy) begin
                    if (p_elapsed != TMO_MAX)
                        p_elapsed = p_elapsed + 24'd1;
                    if (p_elapsed >= p_limit) begin
                        p_busy    = 1'b0;
                        p_status  = ST_TIMEOUT;
                        p_tmo_cnt = p_tmo_cnt + 16'd1;
                        timeouts_seen++;
                    end
                end
            end
            ACT_CLEAR:
            begin
                p_busy     = 1'b0;
                p_asm_len  = 0;
                p_resp_len = 0;
                p_status   = ST_OK;
            end
            ACT_READ_RESP:
            begin
                dlen  = 6'(p_resp_len);
                dbyte = store_byte(p_resp, p_resp_len, w.read_index);
            end
            ACT_READ_LAST:
            begin
                dlen  = 6'(p_last_len);
                dbyte = store_byte(p_last, p_last_len, w.read_index);
            end
            default:
            begin
            end
        endcase
        r.status        = p_status;
        r.busy_flag     = p_busy;
        r.line_event    = ev;
        r.accepted      = acc;
        r.data_length   = dlen;
        r.data_byte     = dbyte;
        r.error_total   = p_err_cnt;
        r.timeout_total = p_tmo_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    function automatic string fmt(input out_word_t o);
        return $sformatf("st=%0d busy=%0d ev=%0d acc=%0d len=%0d byte=%02h err=%0d tmo=%0d",
                         o.status, o.busy_flag, o.line_event, o.accepted, o.data_length,
                         o.data_byte, o.error_total, o.timeout_total);
    endfunction

    function automatic bit same_word(input out_word_t a, input out_word_t b);
        return a.status === b.status && a.busy_flag === b.busy_flag &&
               a.line_event === b.line_event && a.accepted === b.accepted &&
               a.data_length === b.data_length && a.data_byte === b.data_byte &&
               a.error_total === b.error_total && a.timeout_total === b.timeout_total;
    endfunction

    task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected %s, got %s", $time, what, fmt(want), fmt(got));
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                replies_checked++;
                if (reply_q.size() == 0) begin
                    note_mismatch("reply word with nothing expected", '0, out_word);
                end else begin
                    want = reply_q.pop_front();
                    if (!same_word(want, out_word))
                        note_mismatch("reply word mismatch", want, out_word);
                end
            end
            if (cfg_write) begin
                if (cfg_index == REG_DEFAULT_TIMEOUT)
                    p_def_tmo = cfg_data;
                else
                    p_fwd = cfg_data[0];
            end
            if (in_valid && !in_stall) begin
                want = track_step(in_word);
                if (typed_row)
                    want = typed_word;
                reply_q.push_back(want);
            end
        end
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_word    <= w;
        typed_row  <= typed;
        typed_word <= want;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic in_word_t any_word(input logic [2:0] act);
        in_word_t w;
        w.action      = act;
        w.rx_byte     = 8'($urandom);
        w.cmd_timeout = 24'($urandom);
        w.read_index  = 6'($urandom);
        return w;
    endfunction

    task automatic send_rx(input logic [7:0] c);
        in_word_t w;
        w         = any_word(ACT_RX_BYTE);
        w.rx_byte = c;
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_rx(s[i]);
    endtask

    task automatic send_printable(input int n);
        repeat (n) send_rx(8'($urandom_range(32, 126)));
    endtask

    task automatic send_digits();
        repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(48, 57)));
    endtask

    task automatic end_line();
        if ($urandom_range(0, 2) != 0)
            send_rx(CHR_CR);
        send_rx(CHR_LF);
    endtask

    task automatic send_start(input logic [23:0] tmo);
        in_word_t w;
        w             = any_word(ACT_START);
        w.cmd_timeout = tmo;
        send_word(w, 1'b0, '0);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(any_word(ACT_TICK), 1'b0, '0);
    endtask

    task automatic send_read(input logic [2:0] act);
        in_word_t w;
        w = any_word(act);
        if ($urandom_range(0, 1) == 0)
            w.read_index = 6'($urandom_range(0, 7));
        send_word(w, 1'b0, '0);
    endtask

    // "+XXXX: nn" style information line
    task automatic info_line();
        send_rx(CHR_PLUS);
        repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(65, 90)));
        send_rx(CHR_COLON);
        send_rx(8'h20);
        send_digits();
        end_line();
    endtask

    task automatic command_exchange();
        int          tsel;
        int          fin;
        logic [23:0] tmo;
        tsel = $urandom_range(0, 9);
        if (tsel < 4)
            tmo = '0;
        else if (tsel < 8)
            tmo = 24'($urandom_range(1, 6));
        else if (tsel == 8)
            tmo = TMO_MAX;
        else
            tmo = 24'($urandom);
        send_start(tmo);
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: info_line();
                1:
                begin
                    send_printable($urandom_range(1, 12));
                    end_line();
                end
                2: send_ticks(1);
                default:
                begin
                    send_text("AT");
                    end_line();
                end
            endcase
        end
        fin = $urandom_range(0, 9);
        case (fin)
            0, 1, 2, 3: send_text("OK");
            4: send_text("ERROR");
            5:
            begin
                send_text("+CME ERROR: ");
                send_digits();
            end
            6:
            begin
                send_text("+CMS ERROR: ");
                send_digits();
            end
            7: send_ticks($urandom_range(1, 8));
            8:
            begin
                // near misses of the final texts
                case ($urandom_range(0, 3))
                    0: send_text("OKAY");
                    1: send_text("ERRORS");
                    2: send_text("+CME ERRO");
                    default: send_text("O");
                endcase
            end
            default: send_text("+CMS ERROR");
        endcase
        if (fin != 7)
            end_line();
    endtask

    task automatic random_scenario();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            command_exchange();
        end else if (pick < 60) begin
            if ($urandom_range(0, 1) == 0) begin
                info_line();
            end else begin
                send_printable($urandom_range(0, 10));
                end_line();
            end
        end else if (pick < 72) begin
            repeat ($urandom_range(1, 4))
                send_read(($urandom_range(0, 1) == 0) ? ACT_READ_RESP : ACT_READ_LAST);
        end else if (pick < 78) begin
            send_ticks($urandom_range(1, 6));
        end else if (pick < 88) begin
            repeat ($urandom_range(1, 6))
                send_word(any_word(3'($urandom_range(0, 7))), 1'b0, '0);
        end else if (pick < 92) begin
            send_word(any_word(ACT_CLEAR), 1'b0, '0);
        end else if (pick < 96) begin
            // long line, truncated by the block once it passes 63 stored characters
            if ($urandom_range(0, 1) == 0)
                send_text("+CME ERROR");
            repeat ($urandom_range(55, 75)) begin
                c = 8'($urandom);
                send_rx((c == CHR_LF) ? 8'h7E : c);
            end
            end_line();
        end else begin
            send_rx(CHR_PROMPT);
            if ($urandom_range(0, 1) == 0) begin
                send_printable($urandom_range(1, 8));
                end_line();
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------------
    function automatic out_word_t reply(input logic [1:0] st, input logic busy,
                                        input logic [2:0] ev, input logic acc,
                                        input logic [5:0] len, input logic [15:0] errs,
                                        input logic [15:0] tmos);
        out_word_t o;
        o.status        = st;
        o.busy_flag     = busy;
        o.line_event    = ev;
        o.accepted      = acc;
        o.data_length   = len;
        o.data_byte     = '0;
        o.error_total   = errs;
        o.timeout_total = tmos;
        return o;
    endfunction

    task automatic add_row(input logic [2:0] act, input logic [7:0] c, input logic [23:0] tmo,
                           input logic [5:0] idx, input bit typed, input out_word_t want);
        row_t r;
        r.w.action      = act;
        r.w.rx_byte     = c;
        r.w.cmd_timeout = tmo;
        r.w.read_index  = idx;
        r.typed         = typed;
        r.want          = want;
        directed_rows.push_back(r);
    endtask

    task automatic build_table();
        out_word_t idle;
        idle = reply(ST_OK, 1'b0, EV_NONE, 1'b0, 6'd0, 16'd0, 16'd0);
        add_row(ACT_READ_LAST, 8'h00, 24'd0, 6'd0,  1'b1, idle);
        add_row(ACT_READ_RESP, 8'h00, 24'd0, 6'd63, 1'b1, idle);
        add_row(ACT_TICK,      8'h00, 24'd0, 6'd0,  1'b1, idle);
        add_row(ACT_SPARE_6,   8'h00, 24'd0, 6'd0,  1'b1, idle);
        add_row(ACT_SPARE_7,   8'hFF, TMO_MAX, 6'd63, 1'b1, idle);
        add_row(ACT_RX_BYTE,   CHR_PROMPT, 24'd0, 6'd0, 1'b1,
                reply(ST_OK, 1'b0, EV_UNSOL, 1'b0, 6'd1, 16'd0, 16'd0));
        add_row(ACT_START,     8'h00, 24'd1, 6'd0, 1'b1,
                reply(ST_PENDING, 1'b1, EV_NONE, 1'b1, 6'd0, 16'd0, 16'd0));
        // second start is refused while busy
        add_row(ACT_START,     8'h00, 24'd0, 6'd0, 1'b1,
                reply(ST_PENDING, 1'b1, EV_NONE, 1'b0, 6'd0, 16'd0, 16'd0));
        add_row(ACT_RX_BYTE,   CHR_PLUS,  24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   CHR_COLON, 24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   CHR_LF,    24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_READ_RESP, 8'h00,     24'd0, 6'd1, 1'b0, '0);
        add_row(ACT_TICK,      8'h00,     24'd0, 6'd0, 1'b1,
                reply(ST_TIMEOUT, 1'b0, EV_NONE, 1'b0, 6'd0, 16'd0, 16'd1));
        add_row(ACT_RX_BYTE,   CHR_CR,    24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   CHR_LF,    24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   8'h00,     24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   CHR_LF,    24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_START,     8'h00,     TMO_MAX, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   "E",       24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   "R",       24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   "R",       24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   "O",       24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   "R",       24'd0, 6'd0, 1'b0, '0);
        add_row(ACT_RX_BYTE,   CHR_LF,    24'd0, 6'd0, 1'b1,
                reply(ST_ERROR, 1'b0, EV_FINAL_ERR, 1'b0, 6'd5, 16'd1, 16'd1));
        add_row(ACT_READ_LAST, 8'h00,     24'd0, 6'd4, 1'b0, '0);
        add_row(ACT_CLEAR,     8'h00,     24'd0, 6'd0, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int target;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_word         = '0;
        out_stall       = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_DEFAULT_TIMEOUT;
        cfg_data        = '0;
        typed_row       = 1'b0;
        typed_word      = '0;
        tx_idle_pct     = 20;
        rx_idle_pct     = 69;
        words_sent      = 0;
        replies_checked = 0;
        mismatches      = 0;
        lines_closed    = 0;
        finals_ok       = 0;
        finals_err      = 0;
        timeouts_seen   = 0;
        model_reset();
        build_table();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < 3; ph++) begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(REG_DEFAULT_TIMEOUT, 24'd1);
                    write_reg(REG_FORWARD_UNSOL, 24'd0);
                end
                1:
                begin
                    write_reg(REG_DEFAULT_TIMEOUT, 24'd4);
                    write_reg(REG_FORWARD_UNSOL, 24'd1);
                    tx_idle_pct = 69;
                    rx_idle_pct = 20;
                end
                default:
                begin
                    write_reg(REG_DEFAULT_TIMEOUT, TMO_MAX);
                    write_reg(REG_FORWARD_UNSOL, 24'd1);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_scenario();
        end
        settle();

        $display("summary: %0d words driven, %0d replies checked, %0d mismatches",
                 words_sent, replies_checked, mismatches);
        $display("summary: %0d lines ended (%0d ok, %0d error finals), %0d command timeouts",
                 lines_closed, finals_ok, finals_err, timeouts_seen);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
